[rtl/circle_ring_rasterizer_assert.svh]
// Assertion macros used by the ring rasterizer back end (crr_back).
`ifndef CIRCLE_RING_RASTERIZER_ASSERT_SVH
`define CIRCLE_RING_RASTERIZER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define CRR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CRR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CRR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define CRR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)

`endif

`endif

[rtl/crr_pkg.sv]
// Shared types and constants of the ring rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package crr_pkg;

  localparam int COORD_W  = 10;
  localparam int RADIUS_W = 5;
  localparam int COLOR_W  = 8;
  localparam int ADDR_W   = 20;
  localparam int MASK_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_RADIUS_DEF = 31;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [COORD_W-1:0] LINE_PITCH_RST = COORD_W'(320);
  localparam logic [COORD_W-1:0] LINE_COUNT_RST = COORD_W'(200);

  // Bit i is set when i mod 3 equals 1 (radii that take the stripe color).
  localparam logic [31:0] MOD3_ONE_MASK = 32'h9249_2492;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_PITCH = 2'd0,
    REG_LINE_COUNT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [RADIUS_W-1:0] radius;
    logic [COLOR_W-1:0]  color;
  } ring_cmd_t;

  typedef struct packed {
    logic      valid;
    ring_cmd_t cmd;
  } q_head_t;

endpackage

`default_nettype wire

[rtl/crr_in_if.sv]
// Ring command channel.
`timescale 1ns / 1ps
`default_nettype none

interface crr_in_if;
  logic                          valid;
  logic                          ready;
  logic [crr_pkg::COORD_W-1:0]   center_x;
  logic [crr_pkg::COORD_W-1:0]   center_y;
  logic [crr_pkg::RADIUS_W-1:0]  radius;
  logic [crr_pkg::COLOR_W-1:0]   color_a;
  logic [crr_pkg::COLOR_W-1:0]   color_b;
  logic                          mode;

  modport source(output valid, center_x, center_y, radius, color_a, color_b, mode,
                 input ready);
  modport sink(input valid, center_x, center_y, radius, color_a, color_b, mode,
               output ready);
endinterface

`default_nettype wire

[rtl/crr_out_if.sv]
// Pixel step result channel.
`timescale 1ns / 1ps
`default_nettype none

interface crr_out_if;
  logic                         valid;
  logic                         ready;
  logic [crr_pkg::ADDR_W-1:0]   addr_pp;
  logic [crr_pkg::ADDR_W-1:0]   addr_pm;
  logic [crr_pkg::ADDR_W-1:0]   addr_mp;
  logic [crr_pkg::ADDR_W-1:0]   addr_mm;
  logic [crr_pkg::MASK_W-1:0]   on_screen;
  logic [crr_pkg::COLOR_W-1:0]  pixel_color;
  logic                         last;

  modport source(output valid, addr_pp, addr_pm, addr_mp, addr_mm, on_screen,
                 pixel_color, last, input ready);
  modport sink(input valid, addr_pp, addr_pm, addr_mp, addr_mm, on_screen,
               pixel_color, last, output ready);
endinterface

`default_nettype wire

[rtl/crr_cfg_if.sv]
// Configuration register write channel.
`timescale 1ns / 1ps
`default_nettype none

interface crr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [crr_pkg::CFG_IDX_W-1:0] index;
  logic [crr_pkg::COORD_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/circle_ring_rasterizer.sv]
// Ring rasterizer top level: configuration registers, front end, queue and walker.
//
// Channels: cmd takes one ring command (center, radius, two colors, mode);
// pix gives one result per step of the circle walk: four mirrored pixel
// offsets, an on-screen mask, the ring color and a last mark on the final
// step. cfg writes line_pitch (index 0) and line_count (index 1); it is
// always ready and other indexes are ignored.
// A ring of radius r yields at most 2*r+1 steps. The walker produces one
// step per cycle while pix is not stalled, and it takes the next ring from
// the two-entry command queue only when idle after the last step of a ring,
// so it never works on two rings at once. The first result of a ring passes
// three pipeline registers (coordinates, row products, output) after the
// walker loads the ring.
// Radii above MAX_RADIUS are clamped to it.
// Reset (rst, synchronous) empties the queue and pipeline and loads the
// registers with 320 and 200. When pix is stalled the whole walker pipeline
// holds; the front keeps accepting commands until the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module circle_ring_rasterizer #(
  parameter int MAX_RADIUS = crr_pkg::MAX_RADIUS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  crr_in_if.sink     cmd,
  crr_out_if.source  pix,
  crr_cfg_if.sink    cfg
);

  logic [crr_pkg::COORD_W-1:0] line_pitch;
  logic [crr_pkg::COORD_W-1:0] line_count;
  logic                        push;
  crr_pkg::ring_cmd_t          push_cmd;
  logic                        q_full;
  logic                        pop;
  crr_pkg::q_head_t            head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pitch <= crr_pkg::LINE_PITCH_RST;
      line_count <= crr_pkg::LINE_COUNT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        crr_pkg::REG_LINE_PITCH: line_pitch <= cfg.data;
        crr_pkg::REG_LINE_COUNT: line_count <= cfg.data;
        default: ;
      endcase
    end
  end

  crr_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
    .cmd      (cmd),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  crr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  crr_back #(.MAX_RADIUS(MAX_RADIUS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .line_pitch (line_pitch),
    .line_count (line_count),
    .pix        (pix)
  );

endmodule

`default_nettype wire

[rtl/crr_front.sv]
// Front end: accepts ring commands, clamps the radius and picks the ring color.
`timescale 1ns / 1ps
`default_nettype none

module crr_front #(
  parameter int MAX_RADIUS = crr_pkg::MAX_RADIUS_DEF
) (
  crr_in_if.sink              cmd,
  input  wire logic           q_full,
  output logic                push,
  output crr_pkg::ring_cmd_t  push_cmd
);

  localparam logic [crr_pkg::RADIUS_W-1:0] R_MAX = crr_pkg::RADIUS_W'(MAX_RADIUS);

  logic [crr_pkg::RADIUS_W-1:0] r_sat;
  logic                         stripe;

  assign cmd.ready = !q_full;
  assign push      = cmd.valid && !q_full;

  always_comb begin
    r_sat  = (cmd.radius > R_MAX) ? R_MAX : cmd.radius;
    stripe = cmd.mode && crr_pkg::MOD3_ONE_MASK[r_sat];

    push_cmd.cx     = cmd.center_x;
    push_cmd.cy     = cmd.center_y;
    push_cmd.radius = r_sat;
    push_cmd.color  = stripe ? cmd.color_b : cmd.color_a;
  end

endmodule

`default_nettype wire

[rtl/crr_queue.sv]
// Short command queue between the front end and the ring walker.
`timescale 1ns / 1ps
`default_nettype none

module crr_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire crr_pkg::ring_cmd_t  push_cmd,
  output logic                     full,
  input  wire logic                pop,
  output crr_pkg::q_head_t         head
);

  localparam int DEPTH = crr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  crr_pkg::ring_cmd_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/crr_back.sv]
// Back end: walks the circle recurrence and forms the four pixel offsets per step.
`timescale 1ns / 1ps
`default_nettype none

`include "circle_ring_rasterizer_assert.svh"

module crr_back #(
  parameter int MAX_RADIUS = crr_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire crr_pkg::q_head_t              head,
  output logic                               pop,
  input  wire logic [crr_pkg::COORD_W-1:0]   line_pitch,
  input  wire logic [crr_pkg::COORD_W-1:0]   line_count,
  crr_out_if.source                          pix
);

  localparam int CW       = crr_pkg::COORD_W;
  localparam int RW       = crr_pkg::RADIUS_W;
  localparam int AW       = crr_pkg::ADDR_W;
  localparam int X_W      = RW + 1;
  localparam int Y_W      = RW + 1;
  localparam int D_W      = RW + 7;
  localparam int ROW_W    = CW + 1;
  localparam int COL_W    = CW + 2;
  localparam int STEP_CAP = 2 * MAX_RADIUS + 2;
  localparam int CNT_W    = $clog2(STEP_CAP + 1);

  // Walker state.
  logic                        busy;
  logic [X_W-1:0]              x;
  logic signed [Y_W-1:0]       y;
  logic signed [D_W-1:0]       delta;
  logic [CNT_W-1:0]            n;
  logic [CW-1:0]               cx;
  logic [CW-1:0]               cy;
  logic [crr_pkg::COLOR_W-1:0] color;

  logic [X_W-1:0]              x_next;
  logic signed [Y_W-1:0]       y_next;
  logic signed [D_W-1:0]       delta_next;
  logic [CNT_W-1:0]            n_next;
  logic                        step_last;
  logic signed [D_W-1:0]       err;
  logic signed [D_W-1:0]       y_ext;
  logic signed [D_W-1:0]       xi_ext;
  logic signed [D_W-1:0]       yd_ext;
  logic [X_W-1:0]              x_inc;
  logic signed [Y_W-1:0]       y_dec;

  // Stage 1: pixel coordinates of one step.
  logic                        v1;
  logic [ROW_W-1:0]            row_p1;
  logic signed [COL_W-1:0]     row_m1;
  logic [ROW_W-1:0]            col_p1;
  logic signed [COL_W-1:0]     col_m1;
  logic [crr_pkg::COLOR_W-1:0] color1;
  logic                        last1;

  // Stage 2: row products and bounds flags.
  logic                        v2;
  logic [AW-1:0]               prod_p2;
  logic [AW-1:0]               prod_m2;
  logic [CW-1:0]               col_p2;
  logic [CW-1:0]               col_m2;
  logic [crr_pkg::MASK_W-1:0]  ok2;
  logic [crr_pkg::COLOR_W-1:0] color2;
  logic                        last2;

  logic                        en;
  logic                        colp_ok;
  logic                        colm_ok;
  logic                        rowp_ok;
  logic                        rowm_ok;

  // The whole pipeline moves together; it halts only while a result waits.
  assign en  = !pix.valid || pix.ready;
  assign pop = !busy && head.valid;

  always_comb begin
    x_inc  = x + 1'b1;
    y_dec  = y - Y_W'(1);
    y_ext  = D_W'(y);
    xi_ext = $signed(D_W'(x_inc));
    yd_ext = D_W'(y_dec);
    err    = ((delta + y_ext) <<< 1) - $signed(D_W'(1));

    x_next     = x;
    y_next     = y;
    delta_next = delta;
    if (delta < 0 && err <= 0) begin
      x_next     = x_inc;
      delta_next = delta + (xi_ext <<< 1) + $signed(D_W'(1));
    end else if (delta > 0 && err > 0) begin
      y_next     = y_dec;
      delta_next = delta - ((yd_ext <<< 1) + $signed(D_W'(1)));
    end else begin
      // The diagonal step uses the new x and the old y.
      x_next     = x_inc;
      y_next     = y_dec;
      delta_next = delta + ((xi_ext - y_ext) <<< 1);
    end
    n_next    = n + 1'b1;
    step_last = (y_next < 0) || (n_next == CNT_W'(STEP_CAP));
  end

  always_comb begin
    colp_ok = ({1'b0, col_p1} < {2'b00, line_pitch});
    colm_ok = !col_m1[COL_W-1] && (col_m1[COL_W-2:0] < {1'b0, line_pitch});
    rowp_ok = (row_p1 < {1'b0, line_count});
    rowm_ok = !row_m1[COL_W-1] && (row_m1[COL_W-2:0] < {1'b0, line_count});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      pix.valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (busy && en && step_last) begin
        busy <= 1'b0;
      end
      if (en) begin
        v1        <= busy;
        v2        <= v1;
        pix.valid <= v2;
      end
    end

    if (pop) begin
      cx    <= head.cmd.cx;
      cy    <= head.cmd.cy;
      color <= head.cmd.color;
      x     <= '0;
      y     <= $signed({1'b0, head.cmd.radius});
      delta <= $signed(D_W'(1)) - $signed(D_W'({head.cmd.radius, 1'b0}));
      n     <= '0;
    end else if (busy && en) begin
      x     <= x_next;
      y     <= y_next;
      delta <= delta_next;
      n     <= n_next;
    end

    if (en) begin
      // y is never negative while the walker is busy.
      row_p1 <= ROW_W'(cy) + ROW_W'(y[RW-1:0]);
      row_m1 <= $signed(COL_W'(cy)) - $signed(COL_W'(y[RW-1:0]));
      col_p1 <= ROW_W'(cx) + ROW_W'(x);
      col_m1 <= $signed(COL_W'(cx)) - $signed(COL_W'(x));
      color1 <= color;
      last1  <= step_last;

      prod_p2 <= row_p1[CW-1:0] * line_pitch;
      prod_m2 <= row_m1[CW-1:0] * line_pitch;
      col_p2  <= col_p1[CW-1:0];
      col_m2  <= col_m1[CW-1:0];
      ok2     <= {colm_ok && rowm_ok, colm_ok && rowp_ok,
                  colp_ok && rowm_ok, colp_ok && rowp_ok};
      color2  <= color1;
      last2   <= last1;

      pix.addr_pp     <= ok2[0] ? prod_p2 + AW'(col_p2) : '0;
      pix.addr_pm     <= ok2[1] ? prod_m2 + AW'(col_p2) : '0;
      pix.addr_mp     <= ok2[2] ? prod_p2 + AW'(col_m2) : '0;
      pix.addr_mm     <= ok2[3] ? prod_m2 + AW'(col_m2) : '0;
      pix.on_screen   <= ok2;
      pix.pixel_color <= color2;
      pix.last        <= last2;
    end
  end

  `CRR_ASSERT_IMP(a_step_cap, clk, rst, busy, n < CNT_W'(STEP_CAP), "step count past cap")
  `CRR_ASSERT_NEXT(a_load, clk, rst, pop, busy && n == '0 && x == '0, "ring load failed")
  `CRR_ASSERT_NEXT(a_ring_end, clk, rst, busy && en && step_last, !busy, "walker kept running")
  `CRR_ASSERT_IMP(a_offscreen, clk, rst, pix.valid && !pix.on_screen[3], pix.addr_mm == '0, "off-screen address not zero")

endmodule

`default_nettype wire

[tb/ring_step_checker.sv]
// Scoreboard for the ring rasterizer: predicts every pixel step and compares it.
`timescale 1ns / 1ps

module ring_step_checker (
  input  logic clk,
  input  logic rst,
  crr_in_if    cmd,
  crr_out_if   pix,
  crr_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);
  import crr_pkg::*;

  // The walk is cut off after this many steps even if y has not gone negative.
  localparam int STEP_LIMIT = 2 * MAX_RADIUS_DEF + 2;

  localparam logic [MASK_W-1:0] SEL_PP = 4'b0001;
  localparam logic [MASK_W-1:0] SEL_PM = 4'b0010;
  localparam logic [MASK_W-1:0] SEL_MP = 4'b0100;
  localparam logic [MASK_W-1:0] SEL_MM = 4'b1000;

  typedef struct packed {
    logic [ADDR_W-1:0]  pp;
    logic [ADDR_W-1:0]  pm;
    logic [ADDR_W-1:0]  mp;
    logic [ADDR_W-1:0]  mm;
    logic [MASK_W-1:0]  mask;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_step_t;

  pixel_step_t step_q[$];
  int frame_pitch;
  int frame_lines;

  // Off-screen pixels get address 0 and leave their mask bit clear.
  function automatic logic [ADDR_W-1:0] frame_offset(input int px, input int py,
                                                     input logic [MASK_W-1:0] sel,
                                                     inout logic [MASK_W-1:0] mask);
    if (px < 0 || py < 0 || px >= frame_pitch || py >= frame_lines) return '0;
    mask |= sel;
    return ADDR_W'(py * frame_pitch + px);
  endfunction

  function automatic void trace_ring(input logic [COORD_W-1:0] cx_in,
                                     input logic [COORD_W-1:0] cy_in,
                                     input logic [RADIUS_W-1:0] r_in,
                                     input logic [COLOR_W-1:0] ca,
                                     input logic [COLOR_W-1:0] cb,
                                     input logic striped);
    int cx, cy, r, x, y, delta, err, n;
    logic [COLOR_W-1:0] color;
    logic [MASK_W-1:0] m;
    pixel_step_t st;
    cx = cx_in;
    cy = cy_in;
    r = r_in;
    if (r > MAX_RADIUS_DEF) r = MAX_RADIUS_DEF;
    color = (striped && (r % 3) == 1) ? cb : ca;
    x = 0;
    y = r;
    delta = 1 - 2 * r;
    n = 0;
    while (y >= 0 && n < STEP_LIMIT) begin
      m = '0;
      st.pp = frame_offset(cx + x, cy + y, SEL_PP, m);
      st.pm = frame_offset(cx + x, cy - y, SEL_PM, m);
      st.mp = frame_offset(cx - x, cy + y, SEL_MP, m);
      st.mm = frame_offset(cx - x, cy - y, SEL_MM, m);
      st.mask = m;
      st.color = color;
      err = 2 * (delta + y) - 1;
      if (delta < 0 && err <= 0) begin
        x++;
        delta += 2 * x + 1;
      end else if (delta > 0 && err > 0) begin
        y--;
        delta -= 2 * y + 1;
      end else begin
        x++;
        delta += 2 * (x - y);
        y--;
      end
      n++;
      st.last = (y < 0 || n >= STEP_LIMIT);
      step_q.push_back(st);
    end
  endfunction

  always @(posedge clk) begin : watch
    pixel_step_t got;
    pixel_step_t want;
    if (rst) begin
      step_q.delete();
      frame_pitch = LINE_PITCH_RST;
      frame_lines = LINE_COUNT_RST;
    end else begin
      if (pix.valid && pix.ready) begin
        got = '{pp: pix.addr_pp, pm: pix.addr_pm, mp: pix.addr_mp, mm: pix.addr_mm,
                mask: pix.on_screen, color: pix.pixel_color, last: pix.last};
        if (step_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: pixel step transfer with no ring outstanding: pp=%0d last=%0b",
                     $realtime, got.pp, got.last);
          fail_count++;
        end else begin
          want = step_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("%0t: pixel step mismatch", $realtime);
              $display("  expected pp=%0d pm=%0d mp=%0d mm=%0d mask=%b color=%0d last=%0b",
                       want.pp, want.pm, want.mp, want.mm, want.mask, want.color, want.last);
              $display("  actual   pp=%0d pm=%0d mp=%0d mm=%0d mask=%b color=%0d last=%0b",
                       got.pp, got.pm, got.mp, got.mm, got.mask, got.color, got.last);
            end
            fail_count++;
          end
        end
      end
      // Writes to unknown indexes are dropped by the block.
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_LINE_PITCH) frame_pitch = cfg.data;
        else if (cfg.index == REG_LINE_COUNT) frame_lines = cfg.data;
      end
      if (cmd.valid && cmd.ready)
        trace_ring(cmd.center_x, cmd.center_y, cmd.radius, cmd.color_a, cmd.color_b,
                   cmd.mode);
    end
    pending = step_q.size();
  end

endmodule

[tb/circle_ring_rasterizer_test.sv]
// Top of the ring rasterizer testbench: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 1ps

module circle_ring_rasterizer_test;
  import crr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int PHASES = 7;
  localparam int RINGS_PER_PHASE = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rdy = 1'b0;
  bit   calm = 1'b0;
  int   rdy_hold = 0;
  int   fails;
  int   pending;
  int   cur_pitch;
  int   cur_lines;

  crr_in_if  cmd_ch();
  crr_out_if pix_ch();
  crr_cfg_if cfg_ch();

  assign pix_ch.ready = rdy;

  circle_ring_rasterizer u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .pix(pix_ch),
    .cfg(cfg_ch)
  );

  ring_step_checker u_check (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .pix(pix_ch),
    .cfg(cfg_ch),
    .fail_count(fails),
    .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("circle_ring_rasterizer verification failed");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rdy <= 1'b0;
      rdy_hold <= 0;
    end else if (calm) begin
      rdy <= 1'b1;
    end else if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if (rdy) begin
      rdy <= 1'b0;
      rdy_hold <= gap_len();
    end else begin
      rdy <= 1'b1;
      rdy_hold <= $urandom_range(0, 12);
    end
  end

  // Valid stays high after a transfer so back-to-back rings never toggle it.
  task automatic send_ring(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                           input logic [RADIUS_W-1:0] r, input logic [COLOR_W-1:0] ca,
                           input logic [COLOR_W-1:0] cb, input logic striped);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.center_x <= cx;
    cmd_ch.center_y <= cy;
    cmd_ch.radius   <= r;
    cmd_ch.color_a  <= ca;
    cmd_ch.color_b  <= cb;
    cmd_ch.mode     <= striped;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Centers are biased toward the visible frame so that edges get crossed often.
  task automatic rand_ring();
    int cx_top;
    int cy_top;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    cx_top = (cur_pitch + 32 > 1023) ? 1023 : cur_pitch + 32;
    cy_top = (cur_lines + 32 > 1023) ? 1023 : cur_lines + 32;
    cx = COORD_W'($urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, cx_top));
    cy = COORD_W'($urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, cy_top));
    send_ring(cx, cy, RADIUS_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
              1'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_frame(input int pitch, input int lines, input bit poke_spare);
    write_reg(REG_LINE_PITCH, COORD_W'(pitch));
    write_reg(REG_LINE_COUNT, COORD_W'(lines));
    if (poke_spare) begin
      write_reg(REG_SPARE_A, COORD_W'($urandom));
      write_reg(REG_SPARE_B, COORD_W'($urandom));
    end
    cfg_ch.valid <= 1'b0;
    cur_pitch = pitch;
    cur_lines = lines;
  endtask

  // Waits until every predicted pixel step has been transferred.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int phase_pitch[PHASES];
    int phase_lines[PHASES];
    phase_pitch = '{1023, 1, 0, 640, 0, 0, 1023};
    phase_lines = '{1023, 1, 0, 480, 200, 0, 1};
    phase_pitch[5] = $urandom_range(1, 1023);
    phase_lines[5] = $urandom_range(1, 1023);

    cmd_ch.valid    <= 1'b0;
    cmd_ch.center_x <= '0;
    cmd_ch.center_y <= '0;
    cmd_ch.radius   <= '0;
    cmd_ch.color_a  <= '0;
    cmd_ch.color_b  <= '0;
    cmd_ch.mode     <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_LINE_PITCH;
    cfg_ch.data     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    cur_pitch = LINE_PITCH_RST;
    cur_lines = LINE_COUNT_RST;

    // Directed rings on the reset frame of 320 by 200.
    send_ring(10'd0, 10'd0, 5'd0, 8'h00, 8'hff, 1'b0);
    send_ring(10'd1023, 10'd1023, 5'd31, 8'hff, 8'h00, 1'b1);
    send_ring(10'd160, 10'd100, 5'd31, 8'h5a, 8'ha5, 1'b1);
    send_ring(10'd160, 10'd100, 5'd1, 8'h11, 8'h22, 1'b1);
    send_ring(10'd160, 10'd100, 5'd4, 8'h33, 8'h44, 1'b0);
    send_ring(10'd160, 10'd100, 5'd4, 8'h33, 8'h44, 1'b1);
    send_ring(10'd160, 10'd100, 5'd2, 8'h55, 8'h66, 1'b1);
    send_ring(10'd160, 10'd100, 5'd3, 8'h77, 8'h88, 1'b1);
    send_ring(10'd319, 10'd199, 5'd5, 8'h01, 8'h02, 1'b0);
    send_ring(10'd320, 10'd100, 5'd3, 8'h03, 8'h04, 1'b0);
    send_ring(10'd5, 10'd5, 5'd10, 8'h05, 8'h06, 1'b1);
    send_ring(10'd0, 10'd199, 5'd1, 8'h07, 8'h08, 1'b0);
    send_ring(10'd319, 10'd199, 5'd0, 8'h09, 8'h0a, 1'b0);
    send_ring(10'd320, 10'd200, 5'd0, 8'h0b, 8'h0c, 1'b0);
    send_ring(10'd1023, 10'd0, 5'd7, 8'h80, 8'h7f, 1'b1);
    send_ring(10'd0, 10'd1023, 5'd30, 8'haa, 8'h55, 1'b0);
    send_ring(10'd312, 10'd192, 5'd16, 8'hc3, 8'h3c, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_frame(phase_pitch[p], phase_lines[p], p == 3);
      calm <= (p == 1 || p == 4);
      repeat (RINGS_PER_PHASE) rand_ring();
      drain();
    end

    // Leave room for any stray step transfer before the verdict.
    repeat (16) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("circle_ring_rasterizer verification clean");
    end else begin
      $display("circle_ring_rasterizer verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/crr_pkg.sv
rtl/crr_in_if.sv
rtl/crr_out_if.sv
rtl/crr_cfg_if.sv
rtl/crr_front.sv
rtl/crr_queue.sv
rtl/crr_back.sv
rtl/circle_ring_rasterizer.sv
tb/ring_step_checker.sv
tb/circle_ring_rasterizer_test.sv
